// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked implication checks with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== src/tcm4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm4_pkg
// Constants, types and the round/saturate function of the four-lane mixer.
// ----------------------------------------------------------------------------
package tcm4_pkg;

	localparam int LANES    = 4;
	localparam int LANE_W   = $clog2(LANES);
	localparam int MAX_ROWS = 256;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int SAMPLE_W = 16;
	localparam int INDEX_W  = ROW_W + LANE_W;

	typedef logic signed [SAMPLE_W-1:0]   sample_t;
	typedef logic signed [2*SAMPLE_W-1:0] prod_t;
	typedef logic signed [2*SAMPLE_W:0]   acc_t;
	// cos in the upper half, sin in the lower half
	typedef logic [2*SAMPLE_W-1:0]        word_t;

	// Round a Q3.30 sum to Q1.15 (add half an LSB, floor) and saturate.
	function automatic sample_t sat_round(input acc_t acc);
		logic signed [2*SAMPLE_W+1:0] biased;
		logic signed [SAMPLE_W+2:0]   q;
		sample_t                      res;
		biased = {acc[2*SAMPLE_W], acc} + (2*SAMPLE_W+2)'(1 << (SAMPLE_W-2));
		q = biased[2*SAMPLE_W+1:SAMPLE_W-1];
		if (q > (SAMPLE_W+3)'(2**(SAMPLE_W-1) - 1)) begin
			res = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else if (q < -(SAMPLE_W+3)'(2**(SAMPLE_W-1))) begin
			res = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			res = q[SAMPLE_W-1:0];
		end
		return res;
	endfunction

endpackage

// ===== src/table_complex_mixer_4lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_complex_mixer_4lane
// Four-lane table-driven complex down-mixer for Q1.15 IQ samples. A data
// transfer mixes four samples with the cos/sin words of the table row at the
// current position, then advances the position, wrapping at period_vectors.
// Table-write transfers load one lane word and give no result.
// One transfer is taken every cycle while in_stall is low; a data vector passes
// the table read, product register and round/saturate register on its way to
// the output. The table is one 256 x 32-bit memory per lane with one write and
// one registered read port. in_stall rises only when all three stages are full
// and the output is stalled. Writing period_vectors resets the position to
// zero; a period of zero gives 256 rows.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module table_complex_mixer_4lane (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [9:0]          table_index,
	input  logic signed [15:0]  table_cos,
	input  logic signed [15:0]  table_sin,
	input  logic signed [15:0]  in_re_0,
	input  logic signed [15:0]  in_im_0,
	input  logic signed [15:0]  in_re_1,
	input  logic signed [15:0]  in_im_1,
	input  logic signed [15:0]  in_re_2,
	input  logic signed [15:0]  in_im_2,
	input  logic signed [15:0]  in_re_3,
	input  logic signed [15:0]  in_im_3,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  out_re_0,
	output logic signed [15:0]  out_im_0,
	output logic signed [15:0]  out_re_1,
	output logic signed [15:0]  out_im_1,
	output logic signed [15:0]  out_re_2,
	output logic signed [15:0]  out_im_2,
	output logic signed [15:0]  out_re_3,
	output logic signed [15:0]  out_im_3
);

	tcm4_pkg::sample_t smp_re [tcm4_pkg::LANES];
	tcm4_pkg::sample_t smp_im [tcm4_pkg::LANES];

	logic [tcm4_pkg::ROW_W-1:0]  period_q;
	logic [tcm4_pkg::ROW_W-1:0]  pos_q;
	logic [tcm4_pkg::ROW_W-1:0]  pos_inc;

	logic                        v_s1, v_s2, out_valid_q;
	logic                        in_xfer, load_s1, tbl_we, adv_s2, adv_out;
	logic [tcm4_pkg::ROW_W-1:0]  wr_row;
	logic [tcm4_pkg::LANE_W-1:0] wr_lane;

	tcm4_pkg::sample_t re_s1 [tcm4_pkg::LANES];
	tcm4_pkg::sample_t im_s1 [tcm4_pkg::LANES];
	tcm4_pkg::word_t   rd_s1 [tcm4_pkg::LANES];

	tcm4_pkg::prod_t   rc_s2 [tcm4_pkg::LANES];
	tcm4_pkg::prod_t   is_s2 [tcm4_pkg::LANES];
	tcm4_pkg::prod_t   rs_s2 [tcm4_pkg::LANES];
	tcm4_pkg::prod_t   ic_s2 [tcm4_pkg::LANES];

	tcm4_pkg::sample_t out_re_q [tcm4_pkg::LANES];
	tcm4_pkg::sample_t out_im_q [tcm4_pkg::LANES];

	assign smp_re[0] = in_re_0;
	assign smp_im[0] = in_im_0;
	assign smp_re[1] = in_re_1;
	assign smp_im[1] = in_im_1;
	assign smp_re[2] = in_re_2;
	assign smp_im[2] = in_im_2;
	assign smp_re[3] = in_re_3;
	assign smp_im[3] = in_im_3;

	// Handshake and stage advance
	assign adv_out  = v_s2 && (!out_valid_q || !out_stall);
	assign adv_s2   = v_s1 && (!v_s2 || adv_out);
	assign in_stall = v_s1 && v_s2 && !adv_out;
	assign in_xfer  = in_valid && !in_stall;
	assign load_s1  = in_xfer && req_type;
	assign tbl_we   = in_xfer && !req_type;

	assign wr_row  = table_index[tcm4_pkg::INDEX_W-1:tcm4_pkg::LANE_W];
	assign wr_lane = table_index[tcm4_pkg::LANE_W-1:0];
	assign pos_inc = pos_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= 1'b1;
			end else if (adv_s2) begin
				v_s1 <= 1'b0;
			end
			if (adv_s2) begin
				v_s2 <= 1'b1;
			end else if (adv_out) begin
				v_s2 <= 1'b0;
			end
			out_valid_q <= adv_out || (out_valid_q && out_stall);
		end
	end

	// Period register and oscillator position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= tcm4_pkg::ROW_W'(1);
			pos_q    <= '0;
		end else if (cfg_wr_en) begin
			period_q <= cfg_wr_data;
			pos_q    <= '0;
		end else if (load_s1) begin
			pos_q <= (pos_inc == period_q) ? '0 : pos_inc;
		end
	end

	// Per-lane table memory, read into stage 1 with the samples
	for (genvar l = 0; l < tcm4_pkg::LANES; l++) begin : g_lane
		tcm4_pkg::word_t tbl_mem [tcm4_pkg::MAX_ROWS];

		always_ff @(posedge clk) begin
			if (tbl_we && wr_lane == tcm4_pkg::LANE_W'(l)) begin
				tbl_mem[wr_row] <= {table_cos, table_sin};
			end
			if (load_s1) begin
				rd_s1[l] <= tbl_mem[pos_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			re_s1 <= smp_re;
			im_s1 <= smp_im;
		end
	end

	// Stage 2: the four products of each lane
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int l = 0; l < tcm4_pkg::LANES; l++) begin
				rc_s2[l] <= tcm4_pkg::prod_t'(re_s1[l])
					* tcm4_pkg::prod_t'($signed(rd_s1[l][2*tcm4_pkg::SAMPLE_W-1:tcm4_pkg::SAMPLE_W]));
				is_s2[l] <= tcm4_pkg::prod_t'(im_s1[l])
					* tcm4_pkg::prod_t'($signed(rd_s1[l][tcm4_pkg::SAMPLE_W-1:0]));
				rs_s2[l] <= tcm4_pkg::prod_t'(re_s1[l])
					* tcm4_pkg::prod_t'($signed(rd_s1[l][tcm4_pkg::SAMPLE_W-1:0]));
				ic_s2[l] <= tcm4_pkg::prod_t'(im_s1[l])
					* tcm4_pkg::prod_t'($signed(rd_s1[l][2*tcm4_pkg::SAMPLE_W-1:tcm4_pkg::SAMPLE_W]));
			end
		end
	end

	// Output register: combine, round and saturate
	always_ff @(posedge clk) begin
		if (adv_out) begin
			for (int l = 0; l < tcm4_pkg::LANES; l++) begin
				out_re_q[l] <= tcm4_pkg::sat_round(
					tcm4_pkg::acc_t'(rc_s2[l]) - tcm4_pkg::acc_t'(is_s2[l]));
				out_im_q[l] <= tcm4_pkg::sat_round(
					tcm4_pkg::acc_t'(rs_s2[l]) + tcm4_pkg::acc_t'(ic_s2[l]));
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_re_0  = out_re_q[0];
	assign out_im_0  = out_im_q[0];
	assign out_re_1  = out_re_q[1];
	assign out_im_1  = out_im_q[1];
	assign out_re_2  = out_re_q[2];
	assign out_im_2  = out_im_q[2];
	assign out_re_3  = out_re_q[3];
	assign out_im_3  = out_im_q[3];

	// Checks
	`CHK_IMPLY(a_stall_only_full, clk, arst_n, in_stall, v_s1 && v_s2 && out_valid_q)
	`CHK_NEXT(a_cfg_clears_pos, clk, arst_n, cfg_wr_en, pos_q == '0)
	`CHK_IMPLY(a_pos_in_period, clk, arst_n, 1'b1, period_q == '0 || pos_q < period_q)
	`CHK_NEXT(a_result_shown, clk, arst_n, adv_out, out_valid)

endmodule
